// ===== sv/gbe_pkg.sv =====
// shared types and codes for the gap buffer engine
package gbe_pkg;

  localparam int OP_W   = 2;
  localparam int POS_W  = 11;
  localparam int CNT_W  = 11;
  localparam int VAL_W  = 8;
  localparam int RD_W   = 8;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 11;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_INC    = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] value;
  } gbe_in_t;

  typedef struct packed {
    logic [RD_W-1:0]   read_data;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;
  } gbe_out_t;

endpackage

// ===== sv/gbe_ram.sv =====
// element store: one write port, one registered read port
module gbe_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/gap_buffer_engine.sv =====
// gap buffer engine top level: sequencer, gap registers and element store
//
// usage
//   one input word carries an operation: insert, delete range, read or
//   increment range. each accepted word yields exactly one result word with
//   read data, status and the length after the operation.
//   in_stall is high from the cycle after a word is accepted until its result
//   has been loaded into the output register; while out_stall holds the
//   previous result, the new result waits and the input side stays stalled.
//   steps after accept: a rejected word (range or full) goes straight to the
//   response state; a read passes the read and read-wait states; insert and
//   delete first move the gap element by element to the position, then apply
//   the edit; increment walks its count of elements in the stream below;
//   every operation ends in the response state.
//   the gap move and the increment share one read-then-write stream on the
//   element store, one element per cycle; that stream sets the throughput.
//   out_stall only delays loading the output register; a waiting result holds.
//   reset empties the buffer (gap covers the whole store); the store itself
//   is not cleared and entries are only read after being written.
module gap_buffer_engine #(
  parameter int CAPACITY  = 1024,
  parameter int ELEM_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gbe_pkg::gbe_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gbe_pkg::gbe_out_t  out_data
);

  import gbe_pkg::*;

  // address width of the store, width of counts that reach CAPACITY,
  // and a compare width wide enough for both those and the input fields
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOVE = 3'd1;
  localparam logic [2:0] S_INC  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_RDW  = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        gs_r, gs_nxt;       // gap start
  logic [CW-1:0]        gsz_r, gsz_nxt;     // gap size
  logic [CW-1:0]        used_r, used_nxt;   // elements held
  logic                 pend_r, pend_nxt;   // read issued, its write still pending
  logic [AW-1:0]        pend_addr_r, pend_addr_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        lp_r, lp_nxt;       // logical pointer for increment
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic [STAT_W-1:0]    status_r, status_nxt;
  logic [RD_W-1:0]      rdata_r, rdata_nxt;
  logic                 out_valid_r, out_valid_nxt;
  gbe_out_t             out_data_r, out_data_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ELEM_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [ELEM_BITS-1:0] ram_rdata;

  logic                 accept;
  logic [WW-1:0]        pos_w, cnt_w, used_w, cap_w, avail_w;
  logic [CW-1:0]        lsrc, phys;
  logic                 go_left, go_right;

  gbe_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (ELEM_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pos_w   = WW'(in_data.position);
  assign cnt_w   = WW'(in_data.count);
  assign used_w  = WW'(used_r);
  assign cap_w   = WW'(CAPACITY);
  assign avail_w = used_w - pos_w;

  // shared logical-to-physical mapping around the gap
  assign lsrc = (state_r == S_INC) ? lp_r : pos_r;
  assign phys = (lsrc < gs_r) ? lsrc : lsrc + gsz_r;

  assign go_left  = (pos_r < gs_r);
  assign go_right = (pos_r > gs_r);

  always_comb begin
    state_nxt     = state_r;
    gs_nxt        = gs_r;
    gsz_nxt       = gsz_r;
    used_nxt      = used_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    lp_nxt        = lp_r;
    val_nxt       = val_r;
    status_nxt    = status_r;
    rdata_nxt     = rdata_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = pend_addr_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_data.opcode;
          val_nxt    = in_data.value;
          status_nxt = ST_DONE;
          rdata_nxt  = '0;
          pos_nxt    = pos_w[CW-1:0];
          lp_nxt     = pos_w[CW-1:0];
          cnt_nxt    = cnt_w[CW-1:0];
          state_nxt  = S_RESP;
          unique case (in_data.opcode)
            OP_INSERT: begin
              if (pos_w > used_w) begin
                status_nxt = ST_RANGE;
              end else if (used_w >= cap_w || gsz_r == '0) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_MOVE;
              end
            end
            OP_DELETE: begin
              if (pos_w > used_w) begin
                status_nxt = ST_RANGE;
              end else begin
                // clamp the run to the end of the text
                cnt_nxt   = (cnt_w < avail_w) ? cnt_w[CW-1:0] : avail_w[CW-1:0];
                state_nxt = S_MOVE;
              end
            end
            OP_READ: begin
              if (pos_w >= used_w) begin
                status_nxt = ST_RANGE;
              end else begin
                state_nxt = S_RD;
              end
            end
            OP_INC: begin
              if (pos_w + cnt_w > used_w) begin
                status_nxt = ST_RANGE;
              end else begin
                state_nxt = S_INC;
              end
            end
          endcase
        end
      end

      S_MOVE: begin
        // finish the copy whose read was issued last cycle
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (go_left) begin
          ram_raddr     = AW'(gs_r - 1'b1);
          pend_nxt      = 1'b1;
          pend_addr_nxt = AW'(gs_r - 1'b1 + gsz_r);
          gs_nxt        = gs_r - 1'b1;
        end else if (go_right) begin
          ram_raddr     = AW'(gs_r + gsz_r);
          pend_nxt      = 1'b1;
          pend_addr_nxt = AW'(gs_r);
          gs_nxt        = gs_r + 1'b1;
        end else if (!pend_r) begin
          // gap is in place: apply the edit
          if (op_r == OP_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(gs_r);
            ram_wdata = ELEM_BITS'(val_r);
            gs_nxt    = gs_r + 1'b1;
            gsz_nxt   = gsz_r - 1'b1;
            used_nxt  = used_r + 1'b1;
          end else begin
            gsz_nxt  = gsz_r + cnt_r;
            used_nxt = used_r - cnt_r;
          end
          state_nxt = S_RESP;
        end
      end

      S_INC: begin
        // read-modify-write stream, one element per cycle
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata + ELEM_BITS'(val_r);
        end
        if (cnt_r != '0) begin
          ram_raddr     = AW'(phys);
          pend_nxt      = 1'b1;
          pend_addr_nxt = AW'(phys);
          lp_nxt        = lp_r + 1'b1;
          cnt_nxt       = cnt_r - 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_RESP;
        end
      end

      S_RD: begin
        ram_raddr = AW'(phys);
        state_nxt = S_RDW;
      end

      S_RDW: begin
        rdata_nxt = ram_rdata[RD_W-1:0];
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.read_data = rdata_r;
          out_data_nxt.status    = status_r;
          out_data_nxt.length    = used_w[LEN_W-1:0];
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gs_r        <= '0;
      gsz_r       <= CW'(CAPACITY);
      used_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gs_r        <= gs_nxt;
      gsz_r       <= gsz_nxt;
      used_r      <= used_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    op_r        <= op_nxt;
    pos_r       <= pos_nxt;
    cnt_r       <= cnt_nxt;
    lp_r        <= lp_nxt;
    val_r       <= val_nxt;
    status_r    <= status_nxt;
    rdata_r     <= rdata_nxt;
    out_data_r  <= out_data_nxt;
  end

  // text plus gap always fills the store
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, used_r} + {1'b0, gsz_r}) == (CW + 1)'(CAPACITY))
    else $error("used count and gap size do not add up to capacity");

  // gap start never passes the end of the text
  a_gap_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    gs_r <= used_r)
    else $error("gap start beyond end of text");

  // a pending copy write only exists in the streaming states
  a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_MOVE || state_r == S_INC))
    else $error("pending write outside move or increment");

  // a new result only comes from the response state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result loaded outside response state");

endmodule
